// File: rtl/pksrl_pkg.sv
// pksrl_pkg: shared types, constants and command/status structs of the rate limiter
`timescale 1ns / 1ps
package pksrl_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BYTES     = 8;
	localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
	localparam int IDX_W         = SLOT_W + 1;
	localparam int KEY_W         = 64;
	localparam int LEN_W         = 4;
	localparam int CNT_W         = 16;
	localparam int RATE_W        = 32;
	localparam int DIV_CNT_W     = $clog2(RATE_W) + 1;
	localparam int ENTRY_W       = KEY_W + LEN_W + CNT_W;

	// operation codes
	localparam logic [1:0] OP_OPEN    = 2'd0;
	localparam logic [1:0] OP_CLOSE   = 2'd1;
	localparam logic [1:0] OP_REFRESH = 2'd2;

	// result status codes
	localparam logic [2:0] ST_PASS     = 3'd0;
	localparam logic [2:0] ST_RATE     = 3'd1;
	localparam logic [2:0] ST_REJECT   = 3'd2;
	localparam logic [2:0] ST_REDIRECT = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;
	localparam logic [2:0] ST_RELEASED = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_TOTAL_SPEED = 2'd0;
	localparam logic [1:0] CFG_MIN_RATE    = 2'd1;
	localparam logic [1:0] CFG_MAX_KEY     = 2'd2;
	localparam logic [1:0] CFG_FALLBACK    = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_COMMIT,
		S_RDA,
		S_RDB,
		S_DIV,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_FULL,
		RES_RELEASE,
		RES_DISABLED,
		RES_RATE
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     scan_start;
		logic     scan;
		logic     rd_slot;
		logic     commit;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       pass_open;
		logic       slot_valid;
		logic       speed_zero;
		logic       scan_done;
		logic       full;
		logic       div_done;
	} dp_stat_t;

endpackage

// File: rtl/pksrl_datapath.sv
// pksrl_datapath: config registers, key table, scan pipeline, divider and result registers
`timescale 1ns / 1ps
module pksrl_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [1:0]                      cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic [1:0]                      op,
	input  logic [pksrl_pkg::KEY_W-1:0]     flow_key,
	input  logic [3:0]                      key_bytes,
	input  logic [5:0]                      entry_slot,
	input  logic                            already_limited,
	input  pksrl_pkg::dp_cmd_t              cmd,
	output pksrl_pkg::dp_stat_t             stat,
	output logic [2:0]                      status,
	output logic [31:0]                     rate,
	output logic [5:0]                      slot_out,
	output logic [15:0]                     conn_count
);

	logic [31:0] total_speed_q;
	logic [31:0] min_rate_q;
	logic [3:0]  max_key_q;
	logic        fallback_q;

	logic [1:0]                            op_q;
	logic [pksrl_pkg::KEY_W-1:0]           key_q;
	logic [pksrl_pkg::LEN_W-1:0]           len_q;
	logic [pksrl_pkg::SLOT_W-1:0]          slot_q;
	logic                                  pass_q;

	logic [pksrl_pkg::TABLE_ENTRIES-1:0]   valid_q;
	logic [pksrl_pkg::ENTRY_W-1:0]         mem [pksrl_pkg::TABLE_ENTRIES];
	logic [pksrl_pkg::ENTRY_W-1:0]         rd_q;
	logic [pksrl_pkg::SLOT_W-1:0]          rd_addr;

	logic [pksrl_pkg::IDX_W-1:0]           idx_q;
	logic [pksrl_pkg::SLOT_W-1:0]          cmp_idx_s1;
	logic                                  cmp_vld_s1;
	logic                                  found_q;
	logic                                  free_q;
	logic [pksrl_pkg::SLOT_W-1:0]          match_idx_q;
	logic [pksrl_pkg::SLOT_W-1:0]          free_idx_q;
	logic [pksrl_pkg::CNT_W-1:0]           match_cnt_q;

	logic [pksrl_pkg::SLOT_W-1:0]          hit_q;
	logic [pksrl_pkg::CNT_W-1:0]           cnt_q;
	logic [31:0]                           quot_q;
	logic [pksrl_pkg::CNT_W-1:0]           rem_q;
	logic [pksrl_pkg::DIV_CNT_W-1:0]       divcnt_q;

	logic [pksrl_pkg::KEY_W-1:0]  rd_key;
	logic [pksrl_pkg::LEN_W-1:0]  rd_len;
	logic [pksrl_pkg::CNT_W-1:0]  rd_cnt;
	logic [3:0]                   len_sat;
	logic [3:0]                   len_cap;
	logic [pksrl_pkg::KEY_W-1:0]  key_mask;
	logic [pksrl_pkg::SLOT_W-1:0] hit_nxt;
	logic [pksrl_pkg::CNT_W-1:0]  cnt_nxt;
	logic [pksrl_pkg::CNT_W:0]    div_t;
	logic                         div_ge;
	logic [pksrl_pkg::CNT_W:0]    div_diff;

	assign rd_key = rd_q[pksrl_pkg::ENTRY_W-1 -: pksrl_pkg::KEY_W];
	assign rd_len = rd_q[pksrl_pkg::CNT_W +: pksrl_pkg::LEN_W];
	assign rd_cnt = rd_q[pksrl_pkg::CNT_W-1:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_speed_q <= '0;
			min_rate_q    <= '0;
			max_key_q     <= '0;
			fallback_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pksrl_pkg::CFG_TOTAL_SPEED: total_speed_q <= cfg_data;
				pksrl_pkg::CFG_MIN_RATE:    min_rate_q    <= cfg_data;
				pksrl_pkg::CFG_MAX_KEY:     max_key_q     <= cfg_data[3:0];
				pksrl_pkg::CFG_FALLBACK:    fallback_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// key length saturation, cap and byte mask
	always_comb begin
		len_sat = (key_bytes > 4'(pksrl_pkg::KEY_BYTES)) ? 4'(pksrl_pkg::KEY_BYTES) : key_bytes;
		len_cap = (max_key_q != '0 && len_sat > max_key_q) ? max_key_q : len_sat;
		for (int b = 0; b < 8; b++) begin
			key_mask[8*b +: 8] = (4'(b) < len_cap) ? 8'hff : 8'h00;
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			key_q  <= flow_key & key_mask;
			len_q  <= len_cap;
			slot_q <= entry_slot;
			pass_q <= (total_speed_q == '0) || already_limited || (key_bytes == '0);
		end
	end

	// table read port: requested slot or scan index
	assign rd_addr = cmd.rd_slot ? slot_q : idx_q[pksrl_pkg::SLOT_W-1:0];

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.commit && (op_q == pksrl_pkg::OP_OPEN || op_q == pksrl_pkg::OP_CLOSE)) begin
			mem[hit_nxt] <= (op_q == pksrl_pkg::OP_OPEN) ? {key_q, len_q, cnt_nxt}
			                                             : {rd_key, rd_len, cnt_nxt};
		end
	end

	// scan pipeline: address stage then compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
		end else if (cmd.scan_start) begin
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan && !idx_q[pksrl_pkg::SLOT_W];
			if (cmd.scan && !idx_q[pksrl_pkg::SLOT_W]) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmp_vld_s1) begin
				if (valid_q[cmp_idx_s1] && rd_len == len_q && rd_key == key_q && !found_q) begin
					found_q <= 1'b1;
				end
				if (!valid_q[cmp_idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q[pksrl_pkg::SLOT_W-1:0];
		if (cmp_vld_s1 && valid_q[cmp_idx_s1] && rd_len == len_q && rd_key == key_q
		    && !found_q) begin
			match_idx_q <= cmp_idx_s1;
			match_cnt_q <= rd_cnt;
		end
		if (cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// slot and count after this transaction
	always_comb begin
		hit_nxt = slot_q;
		cnt_nxt = rd_cnt;
		case (op_q)
			pksrl_pkg::OP_OPEN: begin
				hit_nxt = found_q ? match_idx_q : free_idx_q;
				cnt_nxt = found_q ? ((match_cnt_q == '1) ? match_cnt_q : match_cnt_q + 1'b1)
				                  : pksrl_pkg::CNT_W'(1);
			end
			pksrl_pkg::OP_CLOSE: cnt_nxt = (rd_cnt != '0) ? rd_cnt - 1'b1 : '0;
			default: ;
		endcase
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			if (op_q == pksrl_pkg::OP_OPEN) begin
				valid_q[hit_nxt] <= 1'b1;
			end else if (op_q == pksrl_pkg::OP_CLOSE && cnt_nxt == '0) begin
				valid_q[hit_nxt] <= 1'b0;
			end
		end
	end

	// restoring divider, one quotient bit a cycle
	assign div_t    = {rem_q, quot_q[31]};
	assign div_ge   = div_t >= {1'b0, cnt_q};
	assign div_diff = div_t - {1'b0, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divcnt_q <= '0;
		end else if (cmd.commit) begin
			divcnt_q <= '0;
		end else if (cmd.div_step) begin
			divcnt_q <= divcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q  <= hit_nxt;
			cnt_q  <= cnt_nxt;
			quot_q <= total_speed_q;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[30:0], div_ge};
			rem_q  <= div_ge ? div_diff[pksrl_pkg::CNT_W-1:0] : div_t[pksrl_pkg::CNT_W-1:0];
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				pksrl_pkg::RES_FULL: begin
					status <= pksrl_pkg::ST_FULL;
					rate <= '0; slot_out <= '0; conn_count <= '0;
				end
				pksrl_pkg::RES_RELEASE: begin
					status <= pksrl_pkg::ST_RELEASED;
					rate <= '0; slot_out <= slot_q; conn_count <= cnt_nxt;
				end
				pksrl_pkg::RES_DISABLED: begin
					status <= pksrl_pkg::ST_PASS;
					rate <= '0; slot_out <= slot_q; conn_count <= cnt_nxt;
				end
				pksrl_pkg::RES_RATE: begin
					slot_out   <= hit_q;
					conn_count <= cnt_q;
					if (op_q == pksrl_pkg::OP_OPEN && min_rate_q != '0
					    && (cnt_q == '0 || quot_q <= min_rate_q)) begin
						status <= fallback_q ? pksrl_pkg::ST_REDIRECT : pksrl_pkg::ST_REJECT;
						rate   <= '0;
					end else begin
						status <= pksrl_pkg::ST_RATE;
						rate   <= (cnt_q == '0) ? '0 : quot_q;
					end
				end
				default: begin
					status <= pksrl_pkg::ST_PASS;
					rate <= '0; slot_out <= '0; conn_count <= '0;
				end
			endcase
		end
	end

	// status towards the controller
	always_comb begin
		stat.op         = op_q;
		stat.pass_open  = pass_q;
		stat.slot_valid = valid_q[slot_q];
		stat.speed_zero = (total_speed_q == '0);
		stat.scan_done  = idx_q[pksrl_pkg::SLOT_W] && !cmp_vld_s1;
		stat.full       = !found_q && !free_q;
		stat.div_done   = (divcnt_q == pksrl_pkg::DIV_CNT_W'(pksrl_pkg::RATE_W));
	end

endmodule

// File: rtl/pksrl_ctrl.sv
// pksrl_ctrl: sequencing state machine for lookup, update, divide and result
`timescale 1ns / 1ps
module pksrl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  pksrl_pkg::dp_stat_t  stat,
	output pksrl_pkg::dp_cmd_t   cmd,
	output logic                 busy,
	output logic                 done
);

	pksrl_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pksrl_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pksrl_pkg::S_IDLE: if (start) state_nxt = pksrl_pkg::S_DECIDE;
			pksrl_pkg::S_DECIDE: begin
				case (stat.op)
					pksrl_pkg::OP_OPEN:
						state_nxt = stat.pass_open ? pksrl_pkg::S_EMIT : pksrl_pkg::S_SCAN;
					pksrl_pkg::OP_CLOSE, pksrl_pkg::OP_REFRESH:
						state_nxt = stat.slot_valid ? pksrl_pkg::S_RDA : pksrl_pkg::S_EMIT;
					default: state_nxt = pksrl_pkg::S_EMIT;
				endcase
			end
			pksrl_pkg::S_SCAN:   if (stat.scan_done) state_nxt = pksrl_pkg::S_COMMIT;
			pksrl_pkg::S_COMMIT: state_nxt = stat.full ? pksrl_pkg::S_EMIT : pksrl_pkg::S_DIV;
			pksrl_pkg::S_RDA:    state_nxt = pksrl_pkg::S_RDB;
			pksrl_pkg::S_RDB:
				state_nxt = (stat.op == pksrl_pkg::OP_CLOSE || stat.speed_zero)
				            ? pksrl_pkg::S_EMIT : pksrl_pkg::S_DIV;
			pksrl_pkg::S_DIV:    if (stat.div_done) state_nxt = pksrl_pkg::S_EMIT;
			pksrl_pkg::S_EMIT:   state_nxt = pksrl_pkg::S_IDLE;
			default:             state_nxt = pksrl_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.res_sel = pksrl_pkg::RES_ZERO;
		unique case (state_q)
			pksrl_pkg::S_IDLE: cmd.load = start;
			pksrl_pkg::S_DECIDE: begin
				cmd.scan_start = 1'b1;
				if (!((stat.op == pksrl_pkg::OP_OPEN && !stat.pass_open)
				      || ((stat.op == pksrl_pkg::OP_CLOSE || stat.op == pksrl_pkg::OP_REFRESH)
				          && stat.slot_valid))) begin
					cmd.res_load = 1'b1;
				end
			end
			pksrl_pkg::S_SCAN: cmd.scan = 1'b1;
			pksrl_pkg::S_COMMIT: begin
				if (stat.full) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pksrl_pkg::RES_FULL;
				end else begin
					cmd.commit = 1'b1;
				end
			end
			pksrl_pkg::S_RDA: cmd.rd_slot = 1'b1;
			pksrl_pkg::S_RDB: begin
				cmd.commit = 1'b1;
				if (stat.op == pksrl_pkg::OP_CLOSE) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pksrl_pkg::RES_RELEASE;
				end else if (stat.speed_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pksrl_pkg::RES_DISABLED;
				end
			end
			pksrl_pkg::S_DIV: begin
				if (stat.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pksrl_pkg::RES_RATE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != pksrl_pkg::S_IDLE);
	assign done = (state_q == pksrl_pkg::S_EMIT);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("controller not idle after result");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pksrl_pkg::S_DIV && stat.div_done |=> done)
		else $error("divide finished without a result");

endmodule

// File: rtl/per_key_shared_rate_limiter.sv
// per_key_shared_rate_limiter: top level joining controller and datapath
//
// channel  | handshake                | payload
// ---------+--------------------------+-----------------------------------------------
// command  | start, busy              | op, flow_key, key_bytes, entry_slot, already_limited
// result   | done (one-cycle strobe)  | status, rate, slot_out, conn_count
// config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// open: capture and decide, table scan, update, divide, result; the table scan (one entry a
// cycle through the registered read port) and the bit-serial divider dominate its time.
// refresh reads the slot, updates and divides; close reads and updates; passes go straight to the result.
// reset clears config, valid bits and control; no clearing pass is needed.
// the result strobe lasts one cycle and cannot be held off; busy drops after it.
`timescale 1ns / 1ps
module per_key_shared_rate_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [63:0] flow_key,
	input  logic [3:0]  key_bytes,
	input  logic [5:0]  entry_slot,
	input  logic        already_limited,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] rate,
	output logic [5:0]  slot_out,
	output logic [15:0] conn_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	pksrl_pkg::dp_cmd_t  cmd;
	pksrl_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	pksrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	pksrl_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.op              (op),
		.flow_key        (flow_key),
		.key_bytes       (key_bytes),
		.entry_slot      (entry_slot),
		.already_limited (already_limited),
		.cmd             (cmd),
		.stat            (stat),
		.status          (status),
		.rate            (rate),
		.slot_out        (slot_out),
		.conn_count      (conn_count)
	);

endmodule
